>>> src/clc_pkg.sv
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types and codes of the circular list engine.
// ----------------------------------------------------------------------------
package clc_pkg;

	localparam int DefCapacity = 16;
	localparam int ValueW      = 32;
	localparam int CountW      = 5;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [ValueW-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic              do_append;
		logic              do_delete;
		logic [ValueW-1:0] value;
	} ctl_t;

	typedef struct packed {
		logic              hit;
		logic              first;
		logic              wrap;
		logic [ValueW-1:0] res;
	} chain_t;

endpackage

>>> src/clc_req_if.sv
// ----------------------------------------------------------------------------
// clc_req_if
// Request channel: one command and its value per transaction.
// ----------------------------------------------------------------------------
interface clc_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  command;
	logic signed [31:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface

>>> src/clc_rsp_if.sv
// ----------------------------------------------------------------------------
// clc_rsp_if
// Response channel: one result per request transaction.
// ----------------------------------------------------------------------------
interface clc_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic        [1:0]  status;
	logic        [4:0]  entry_count;

	modport source (output valid, output result_value, output status, output entry_count,
		input ready);
	modport sink (input valid, input result_value, input status, input entry_count,
		output ready);
endinterface

>>> src/clc_cell.sv
// ----------------------------------------------------------------------------
// clc_cell
// One ring position: holds an entry, compares it with the request value and
// takes its right neighbour's entry when a deletion closes the gap.
// ----------------------------------------------------------------------------
module clc_cell
	import clc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	input  logic              left_valid,
	input  logic [ValueW-1:0] right_entry,
	input  logic              right_valid,
	input  chain_t            cin,
	output chain_t            cout,
	output logic [ValueW-1:0] entry,
	output logic              valid
);

	logic [ValueW-1:0] entry_q;
	logic              valid_q;
	logic              match;
	logic              shift;
	logic              load;

	assign match = valid_q && (entry_q == ctl.value);
	assign shift = ctl.do_delete && (cin.hit || match);
	assign load  = ctl.do_append && !valid_q && left_valid;

	always_comb begin
		cout.hit   = cin.hit || match;
		cout.first = match && !cin.hit;
		cout.wrap  = cin.wrap || (cin.first && !valid_q);
		cout.res   = cin.res | ((cin.first && valid_q) ? entry_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= right_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= right_entry;
		end else if (load) begin
			entry_q <= ctl.value;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

>>> src/circular_list_engine_unit.sv
// ----------------------------------------------------------------------------
// circular_list_engine_unit
// Bounded ordered ring of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Each request transaction is an append, a delete of the first match, a
// successor query or a no-op, and gives exactly one registered response. Every
// cell compares its entry with the request value in the same cycle, and a
// deletion closes the gap by moving each later entry one cell towards the head,
// so a new request can be taken in every cycle unless the response stalls; the
// response register decouples the two channels. The search and the successor
// pick ripple along the row of CAPACITY cells, which sets the clock period.
module circular_list_engine_unit
	import clc_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
) (
	input logic       clk,
	input logic       arst_n,
	clc_req_if.sink   request,
	clc_rsp_if.source response
);

	localparam int CntW = $clog2(CAPACITY + 1);

	ctl_t              ctl;
	chain_t            chain [0:CAPACITY];
	logic [ValueW-1:0] entries [0:CAPACITY];
	logic              valids [0:CAPACITY];
	logic [CntW-1:0]   count_q;
	logic [CntW-1:0]   count_nxt;
	logic              accept;
	logic              full;
	logic              any_hit;
	logic              wrap;
	logic [ValueW-1:0] succ;
	logic [ValueW-1:0] result_nxt;
	logic [1:0]        status_nxt;
	logic              out_valid_q;
	logic [ValueW-1:0] result_q;
	logic [1:0]        status_q;
	logic [CountW-1:0] count_out_q;

	assign request.ready = !out_valid_q || response.ready;
	assign accept        = request.valid && request.ready;
	assign full          = (count_q == CntW'(CAPACITY));

	assign chain[0]          = '{hit: 1'b0, first: 1'b0, wrap: 1'b0, res: '0};
	assign entries[CAPACITY] = '0;
	assign valids[CAPACITY]  = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic left_valid;
		if (i == 0) begin : g_head
			assign left_valid = 1'b1;
		end else begin : g_body
			assign left_valid = valids[i-1];
		end
		clc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_valid  (left_valid),
			.right_entry (entries[i+1]),
			.right_valid (valids[i+1]),
			.cin         (chain[i]),
			.cout        (chain[i+1]),
			.entry       (entries[i]),
			.valid       (valids[i])
		);
	end

	assign any_hit = chain[CAPACITY].hit;
	assign wrap    = chain[CAPACITY].wrap || chain[CAPACITY].first;
	assign succ    = wrap ? entries[0] : chain[CAPACITY].res;

	// A cell only shifts at or after a match, so a delete without a hit
	// leaves the row untouched.
	always_comb begin
		ctl.value     = request.value;
		ctl.do_append = accept && (request.command == CMD_APPEND) && !full;
		ctl.do_delete = accept && (request.command == CMD_DELETE);
	end

	always_comb begin
		result_nxt = ALL_ONES;
		status_nxt = ST_DONE;
		count_nxt  = count_q;
		unique case (request.command)
			CMD_APPEND: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = count_q + CntW'(1);
				end
			end
			CMD_DELETE: begin
				if (any_hit) begin
					count_nxt = count_q - CntW'(1);
				end else begin
					status_nxt = ST_MISS;
				end
			end
			CMD_QUERY: begin
				if (any_hit) begin
					result_nxt = succ;
				end else begin
					status_nxt = ST_MISS;
				end
			end
			default: begin
				status_nxt = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q    <= result_nxt;
			status_q    <= status_nxt;
			count_out_q <= CountW'(count_nxt);
		end
	end

	assign response.valid        = out_valid_q;
	assign response.result_value = result_q;
	assign response.status       = status_q;
	assign response.entry_count  = count_out_q;

endmodule

>>> src/clc_checker.sv
// ----------------------------------------------------------------------------
// clc_checker
// Port-level checks of the circular list engine, bound to its top level.
// ----------------------------------------------------------------------------
module clc_checker
	import clc_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [ValueW-1:0] result_value,
	input logic [1:0]        status,
	input logic [CountW-1:0] entry_count
);

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("request transaction without a response");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value) && $stable(status)
		&& $stable(entry_count))
		else $error("stalled response transaction changed");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> entry_count == CountW'(CAPACITY))
		else $error("dropped append while the ring was not full");

	a_fail_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL || status == ST_MISS) |-> result_value == ALL_ONES)
		else $error("failed transaction returned a value");

endmodule

bind circular_list_engine_unit clc_checker #(.CAPACITY(CAPACITY)) u_clc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (request.valid),
	.req_ready    (request.ready),
	.rsp_valid    (response.valid),
	.rsp_ready    (response.ready),
	.result_value (response.result_value),
	.status       (response.status),
	.entry_count  (response.entry_count)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the circular list engine.
// ----------------------------------------------------------------------------
// A short table of commands covers the empty ring, the one-entry ring, the
// full ring, the unused command code and the extreme values. Long runs of
// random appends, deletes and successor queries follow under changing idle
// and stall patterns. Every accepted request transaction is run through a
// behavioural copy of the ring, and each response transaction is compared
// field by field with the oldest expected reply.
module testbench;
	import clc_pkg::*;

	localparam int RingDepth   = DefCapacity;
	localparam int RandomItems = 1450;
	localparam int QuietLimit  = 2000;
	localparam int HoldOff     = 120;

	typedef struct packed {
		logic [ValueW-1:0] result_value;
		logic [1:0]        status;
		logic [CountW-1:0] entry_count;
	} ring_reply_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [ValueW-1:0] value;
		logic              fixed;
		ring_reply_t       reply;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	clc_req_if request ();
	clc_rsp_if response ();

	circular_list_engine_unit #(.CAPACITY(RingDepth)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.response (response)
	);

	logic              item_fixed;
	ring_reply_t       item_reply;
	logic [ValueW-1:0] model_ring [RingDepth];
	int                model_count = 0;
	ring_reply_t       pending_replies [$];
	int                error_count = 0;
	int                quiet_cycles = 0;
	int                send_idle_pct = 0;
	int                stall_pct = 0;
	int                hold_cycles = 0;

	always #2 clk = ~clk;

	function automatic ring_reply_t apply_command(input logic [1:0] command,
		input logic [ValueW-1:0] value);
		ring_reply_t reply;
		int          pos;
		reply.result_value = ALL_ONES;
		reply.status = ST_DONE;
		pos = model_count;
		for (int i = model_count - 1; i >= 0; i--) begin
			if (model_ring[i] == value)
				pos = i;
		end
		case (command)
			CMD_APPEND: begin
				if (model_count < RingDepth) begin
					model_ring[model_count] = value;
					model_count++;
				end else begin
					reply.status = ST_FULL;
				end
			end
			CMD_DELETE: begin
				if (pos == model_count) begin
					reply.status = ST_MISS;
				end else begin
					for (int i = pos; i < model_count - 1; i++)
						model_ring[i] = model_ring[i + 1];
					model_count--;
				end
			end
			CMD_QUERY: begin
				if (pos == model_count)
					reply.status = ST_MISS;
				else
					reply.result_value = model_ring[(pos + 1 == model_count) ? 0 : pos + 1];
			end
			default: begin
			end
		endcase
		reply.entry_count = CountW'(model_count);
		return reply;
	endfunction

	task automatic offer(input logic [1:0] command, input logic [ValueW-1:0] value,
		input logic fixed, input ring_reply_t reply);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			request.valid <= 1'b0;
			@(negedge clk);
		end
		request.valid   <= 1'b1;
		request.command <= command;
		request.value   <= value;
		item_fixed      <= fixed;
		item_reply      <= reply;
		@(posedge clk);
		while (!request.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random(input int count);
		logic [1:0]        command;
		logic [ValueW-1:0] value;
		int                roll;
		bit                filling;
		for (int n = 0; n < count; n++) begin
			filling = (n % 80) < 25;
			roll = $urandom_range(0, 99);
			if (roll < 5)
				command = CMD_NONE;
			else if (roll < 35)
				command = CMD_QUERY;
			else if (roll < (filling ? 90 : 50))
				command = CMD_APPEND;
			else
				command = CMD_DELETE;
			roll = $urandom_range(0, 99);
			if (roll < 70 && model_count > 0)
				value = model_ring[$urandom_range(0, model_count - 1)];
			else if (roll < 85)
				value = int'($urandom_range(0, 5)) - 2;
			else
				value = $urandom();
			offer(command, value, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		ring_reply_t predicted;
		ring_reply_t expected;
		if (arst_n) begin
			if (request.valid && request.ready) begin
				predicted = apply_command(request.command, request.value);
				pending_replies.push_back(item_fixed ? item_reply : predicted);
			end
			if (response.valid && response.ready) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: response with no request outstanding, got %h %h %h", $time,
						response.result_value, response.status, response.entry_count);
					error_count++;
				end else begin
					expected = pending_replies.pop_front();
					if (response.result_value !== expected.result_value) begin
						$display("%0t: result_value expected %h got %h", $time,
							expected.result_value, response.result_value);
						error_count++;
					end
					if (response.status !== expected.status) begin
						$display("%0t: status expected %0d got %0d", $time,
							expected.status, response.status);
						error_count++;
					end
					if (response.entry_count !== expected.entry_count) begin
						$display("%0t: entry_count expected %0d got %0d", $time,
							expected.entry_count, response.entry_count);
						error_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (request.valid && request.ready) || (response.valid && response.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		response.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				response.ready <= 1'b0;
				hold_cycles--;
			end else begin
				response.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin
		script_row_t script [$];
		request.valid   = 1'b0;
		request.command = CMD_APPEND;
		request.value   = '0;
		item_fixed      = 1'b0;
		item_reply      = '0;

		script.push_back(script_row_t'{CMD_QUERY, 32'h0000_0000, 1'b1,
			ring_reply_t'{ALL_ONES, ST_MISS, 5'd0}});
		script.push_back(script_row_t'{CMD_DELETE, 32'h0000_0005, 1'b1,
			ring_reply_t'{ALL_ONES, ST_MISS, 5'd0}});
		script.push_back(script_row_t'{CMD_NONE, 32'hFFFF_FFFF, 1'b1,
			ring_reply_t'{ALL_ONES, ST_DONE, 5'd0}});
		script.push_back(script_row_t'{CMD_APPEND, 32'h7FFF_FFFF, 1'b1,
			ring_reply_t'{ALL_ONES, ST_DONE, 5'd1}});
		script.push_back(script_row_t'{CMD_QUERY, 32'h7FFF_FFFF, 1'b1,
			ring_reply_t'{32'h7FFF_FFFF, ST_DONE, 5'd1}});
		script.push_back(script_row_t'{CMD_DELETE, 32'h7FFF_FFFF, 1'b1,
			ring_reply_t'{ALL_ONES, ST_DONE, 5'd0}});
		script.push_back(script_row_t'{CMD_APPEND, 32'h8000_0000, 1'b1,
			ring_reply_t'{ALL_ONES, ST_DONE, 5'd1}});
		script.push_back(script_row_t'{CMD_APPEND, 32'hFFFF_FFFF, 1'b1,
			ring_reply_t'{ALL_ONES, ST_DONE, 5'd2}});
		script.push_back(script_row_t'{CMD_QUERY, 32'hFFFF_FFFF, 1'b1,
			ring_reply_t'{32'h8000_0000, ST_DONE, 5'd2}});
		script.push_back(script_row_t'{CMD_APPEND, 32'h0000_0000, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'h0000_0001, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'h5555_5555, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'hAAAA_AAAA, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'h0000_FFFF, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'hFFFF_0000, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'hFFFF_FFFE, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'h0000_0002, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'h1234_5678, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'h8765_4321, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'h7FFF_FFFE, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'h8000_0001, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'h0000_0064, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'hFFFF_FF9C, 1'b0, '0});
		script.push_back(script_row_t'{CMD_APPEND, 32'h0000_0007, 1'b1,
			ring_reply_t'{ALL_ONES, ST_FULL, 5'd16}});
		script.push_back(script_row_t'{CMD_QUERY, 32'h0BAD_F00D, 1'b1,
			ring_reply_t'{ALL_ONES, ST_MISS, 5'd16}});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			offer(script[i].command, script[i].value, script[i].fixed, script[i].reply);

		hold_cycles = HoldOff;
		run_random(RandomItems / 4);
		send_idle_pct = 71;
		run_random(RandomItems / 4);
		send_idle_pct = 0;
		stall_pct = 71;
		run_random(RandomItems / 4);
		send_idle_pct = 15;
		stall_pct = 15;
		run_random(RandomItems - 3 * (RandomItems / 4));

		request.valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
